// ----- rtl/mpsa_pkg.sv -----
// Shared types and constants for the multi-pool slab allocator.
// No dependencies; every RTL file of the allocator imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mpsa_pkg;

   // Field widths fixed by the request and response formats.
   localparam int POOL_W   = 2;
   localparam int SLAB_W   = 6;
   localparam int CNT_W    = 7;
   localparam int NPOOL_W  = 3;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 3;

   // Defaults for the top-level size parameters.
   localparam int DEF_MAX_POOLS = 4;
   localparam int DEF_MAX_SLABS = 64;

   // Register reset values.
   localparam logic [NPOOL_W-1:0] RST_POOLS_IN_USE = 3'd4;
   localparam logic [CNT_W-1:0]   RST_SLAB_COUNT   = 7'd64;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POOLS_IN_USE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLABS_POOL0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLABS_POOL1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLABS_POOL2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLABS_POOL3  = 3'd4;

   // Request commands.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ALLOCATED     = 3'd0,
      STATUS_NO_MEMORY     = 3'd1,
      STATUS_FREED         = 3'd2,
      STATUS_NOT_ALLOCATED = 3'd3,
      STATUS_OUTSIDE       = 3'd4
   } status_type;

   typedef struct packed {
      logic              command;
      logic [POOL_W-1:0] pool_number;
      logic [SLAB_W-1:0] slab_number;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [POOL_W-1:0] granted_pool;
      logic [SLAB_W-1:0] granted_slab;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/multi_pool_slab_allocator_unit.sv -----
// Multi-pool slab allocator: bitmap memory, round-robin search and free checks.
// Depends on mpsa_pkg for field widths, codes and the request/response structs.
//
//   Channel  Direction  Handshake          Beat contents
//   req      in         req_valid/stall    command, pool number, slab number
//   rsp      out        rsp_valid/stall    status, granted pool, granted slab
//   csr      in         csr_valid/ready    register index, write data
//
// A free is answered from the one pool bitmap it reads; an allocate reads one bitmap
// per pool searched, up to four pools. The search is paced by the bitmap memory, whose
// single read port delivers one pool bitmap per cycle while no response beat is held.
// Reset is synchronous; the bitmaps read as all free after reset through per-pool
// valid bits, so no clearing pass is needed. A response beat waits in its output
// register under rsp_stall while the next request is accepted; that request's
// evaluation holds until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module multi_pool_slab_allocator_unit
   import mpsa_pkg::*;
#(
   parameter int MAX_POOLS = DEF_MAX_POOLS,
   parameter int MAX_SLABS = DEF_MAX_SLABS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire req_type              req_payload,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      rsp_type              rsp_payload,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]     csr_data
);

   localparam int POOLS = (MAX_POOLS > 4) ? 4 : MAX_POOLS;
   localparam int SLABS = (MAX_SLABS > 64) ? 64 : MAX_SLABS;
   localparam int PW    = (POOLS > 1) ? $clog2(POOLS) : 1;

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } state_type;

   // Configuration registers.
   logic [NPOOL_W-1:0] pools_in_use_ff;
   logic [CNT_W-1:0]   slab_cnt_ff [4];

   // Control state.
   state_type          state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic [SLAB_W-1:0]  slab_ff, slab_in;
   logic [POOL_W-1:0]  cur_ff, cur_in;
   logic [POOL_W-1:0]  first_ff, first_in;
   logic [NPOOL_W-1:0] left_ff, left_in;
   logic [POOL_W-1:0]  start_ff, start_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // Bitmap memory and its read side.
   logic [SLABS-1:0]   bitmap_mem [POOLS];
   logic [POOLS-1:0]   pool_valid_ff;
   logic [SLABS-1:0]   rd_data_ff;
   logic               rd_valid_ff;
   logic [POOL_W-1:0]  rd_pool;
   logic               wr_en;
   logic [SLABS-1:0]   wr_data;

   logic [NPOOL_W-1:0] npools;
   logic [POOL_W-1:0]  start_eff;
   logic [CNT_W-1:0]   lim_raw, lim;
   logic [SLABS-1:0]   word, lim_mask, free_vec, sel_onehot;
   logic               any_free, hit, outside, out_free;
   logic [SLAB_W-1:0]  found_idx, sel_slab;
   logic [NPOOL_W-1:0] cur_inc, first_inc;
   logic [POOL_W-1:0]  cur_next, first_next;

   assign npools    = (pools_in_use_ff > NPOOL_W'(POOLS)) ? NPOOL_W'(POOLS) : pools_in_use_ff;
   assign start_eff = ({1'b0, start_ff} < npools) ? start_ff : '0;

   assign lim_raw = slab_cnt_ff[cur_ff];
   assign lim     = (lim_raw > CNT_W'(SLABS)) ? CNT_W'(SLABS) : lim_raw;

   assign word = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      for (int i = 0; i < SLABS; i++) begin
         lim_mask[i] = (CNT_W'(i) < lim);
      end
   end

   assign free_vec = ~word & lim_mask;
   assign any_free = |free_vec;

   // Lowest clear slab below the pool's slab count.
   always_comb begin
      found_idx = '0;
      for (int i = SLABS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            found_idx = SLAB_W'(i);
         end
      end
   end

   assign sel_slab   = (cmd_ff == CMD_FREE) ? slab_ff : found_idx;
   assign sel_onehot = SLABS'(1) << sel_slab;
   assign hit        = (word & sel_onehot) != '0;
   assign outside    = ({1'b0, cur_ff} >= npools) || ({1'b0, slab_ff} >= lim);

   assign cur_inc    = {1'b0, cur_ff} + NPOOL_W'(1);
   assign cur_next   = (cur_inc >= npools) ? '0 : cur_inc[POOL_W-1:0];
   assign first_inc  = {1'b0, first_ff} + NPOOL_W'(1);
   assign first_next = (first_inc >= npools) ? '0 : first_inc[POOL_W-1:0];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      slab_in      = slab_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      left_in      = left_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_pool      = cur_ff;
      wr_en        = 1'b0;
      wr_data      = word;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload.command;
               slab_in  = req_payload.slab_number;
               cur_in   = (req_payload.command == CMD_FREE) ? req_payload.pool_number
                                                            : start_eff;
               first_in = start_eff;
               left_in  = npools;
               rd_pool  = cur_in;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (out_free) begin
               if (cmd_ff == CMD_FREE) begin
                  rsp_in.granted_pool = cur_ff;
                  rsp_in.granted_slab = slab_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (outside) begin
                     rsp_in.status = STATUS_OUTSIDE;
                  end else if (hit) begin
                     rsp_in.status = STATUS_FREED;
                     wr_en   = 1'b1;
                     wr_data = word & ~sel_onehot;
                  end else begin
                     rsp_in.status = STATUS_NOT_ALLOCATED;
                  end
               end else if (left_ff != '0 && any_free) begin
                  rsp_in.status       = STATUS_ALLOCATED;
                  rsp_in.granted_pool = cur_ff;
                  rsp_in.granted_slab = found_idx;
                  rsp_valid_in = 1'b1;
                  wr_en        = 1'b1;
                  wr_data      = word | sel_onehot;
                  start_in     = first_next;
                  state_in     = S_IDLE;
               end else if (left_ff > NPOOL_W'(1)) begin
                  // Pool full: fetch the next pool's bitmap and keep searching.
                  left_in = left_ff - NPOOL_W'(1);
                  cur_in  = cur_next;
                  rd_pool = cur_next;
               end else begin
                  rsp_in.status       = STATUS_NO_MEMORY;
                  rsp_in.granted_pool = '0;
                  rsp_in.granted_slab = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         start_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         pool_valid_ff   <= '0;
         pools_in_use_ff <= RST_POOLS_IN_USE;
         for (int k = 0; k < 4; k++) begin
            slab_cnt_ff[k] <= RST_SLAB_COUNT;
         end
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            pool_valid_ff[cur_ff[PW-1:0]] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_POOLS_IN_USE: pools_in_use_ff <= csr_data[NPOOL_W-1:0];
               CSR_SLABS_POOL0:  slab_cnt_ff[0]  <= csr_data;
               CSR_SLABS_POOL1:  slab_cnt_ff[1]  <= csr_data;
               CSR_SLABS_POOL2:  slab_cnt_ff[2]  <= csr_data;
               CSR_SLABS_POOL3:  slab_cnt_ff[3]  <= csr_data;
               default: ;
            endcase
         end
      end
      cmd_ff      <= cmd_in;
      slab_ff     <= slab_in;
      cur_ff      <= cur_in;
      first_ff    <= first_in;
      left_ff     <= left_in;
      rsp_ff      <= rsp_in;
      rd_valid_ff <= pool_valid_ff[rd_pool[PW-1:0]];
   end

   // One bitmap per pool; a pool that was never written reads as all free.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[cur_ff[PW-1:0]] <= wr_data;
      end
      rd_data_ff <= bitmap_mem[rd_pool[PW-1:0]];
   end

   // Only pools that take part in allocation are ever written.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, cur_ff} < npools))
      else $error("bitmap write to a pool outside the active range");

   // An allocate sets a clear slab and a free clears a set one.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (hit == cmd_ff))
      else $error("bitmap update does not flip the selected slab");

   // The search never visits more pools than are in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && cmd_ff == CMD_ALLOC) |-> (left_ff <= npools))
      else $error("pool search count exceeds the pools in use");

   // A response beat is only raised by the evaluation step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EVAL))
      else $error("response raised outside evaluation");

endmodule

`default_nettype wire

// ----- verif/slab_grant_checker.sv -----
// Scoreboard for the multi-pool slab allocator: follows register writes, predicts every
// response beat from its own copy of the bitmaps and compares it with the block's output.
// Depends on mpsa_pkg for the beat structs, status codes and register indexes.
`timescale 1ns / 1ps

module slab_grant_checker
   import mpsa_pkg::*;
#(
   parameter int MAX_POOLS = DEF_MAX_POOLS,
   parameter int MAX_SLABS = DEF_MAX_SLABS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_data,
   output int                   mismatch_count,
   output int                   grants_pending
);

   logic [NPOOL_W-1:0] pools_reg;
   logic [CNT_W-1:0]   slabs_reg [4];
   logic [63:0]        taken_map [4];
   logic [POOL_W-1:0]  rr_start;
   rsp_type            expected_grants [$];

   function automatic int unsigned live_pools();
      int unsigned n;
      n = pools_reg;
      if (n > MAX_POOLS) n = MAX_POOLS;
      if (n > 4) n = 4;
      return n;
   endfunction

   function automatic int unsigned pool_capacity(int unsigned pool);
      int unsigned n;
      n = slabs_reg[pool];
      if (n > MAX_SLABS) n = MAX_SLABS;
      if (n > 64) n = 64;
      return n;
   endfunction

   // Applies one request beat to the bitmaps and returns the response it must produce.
   function automatic rsp_type apply_request(req_type beat);
      rsp_type     grant;
      int unsigned pools;
      int unsigned idx;
      int unsigned first;
      int unsigned cap;
      bit          hit;
      pools = live_pools();
      grant = '0;
      hit   = 1'b0;
      if (beat.command == CMD_ALLOC) begin
         idx   = (rr_start < pools) ? rr_start : 0;
         first = idx;
         for (int j = 0; j < pools && !hit; j++) begin
            cap = pool_capacity(idx);
            for (int s = 0; s < cap && !hit; s++) begin
               if (!taken_map[idx][s]) begin
                  hit                = 1'b1;
                  taken_map[idx][s]  = 1'b1;
                  rr_start           = POOL_W'((first + 1 >= pools) ? 0 : first + 1);
                  grant.status       = STATUS_ALLOCATED;
                  grant.granted_pool = POOL_W'(idx);
                  grant.granted_slab = SLAB_W'(s);
               end
            end
            if (!hit) idx = (idx + 1 >= pools) ? 0 : idx + 1;
         end
         if (!hit) grant.status = STATUS_NO_MEMORY;
      end else begin
         grant.granted_pool = beat.pool_number;
         grant.granted_slab = beat.slab_number;
         if (beat.pool_number >= pools || beat.slab_number >= pool_capacity(beat.pool_number))
            grant.status = STATUS_OUTSIDE;
         else if (taken_map[beat.pool_number][beat.slab_number]) begin
            taken_map[beat.pool_number][beat.slab_number] = 1'b0;
            grant.status = STATUS_FREED;
         end else
            grant.status = STATUS_NOT_ALLOCATED;
      end
      return grant;
   endfunction

   task automatic compare_grant(rsp_type got);
      rsp_type want;
      if (expected_grants.size() == 0) begin
         $display("%0t: unexpected response beat, got status %0d pool %0d slab %0d",
                  $time, got.status, got.granted_pool, got.granted_slab);
         mismatch_count++;
      end else begin
         want = expected_grants.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            mismatch_count++;
         end
         if (got.granted_pool !== want.granted_pool) begin
            $display("%0t: granted_pool expected %0d, got %0d",
                     $time, want.granted_pool, got.granted_pool);
            mismatch_count++;
         end
         if (got.granted_slab !== want.granted_slab) begin
            $display("%0t: granted_slab expected %0d, got %0d",
                     $time, want.granted_slab, got.granted_slab);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pools_reg = RST_POOLS_IN_USE;
         foreach (slabs_reg[p]) slabs_reg[p] = RST_SLAB_COUNT;
         foreach (taken_map[p]) taken_map[p] = '0;
         rr_start = '0;
         expected_grants.delete();
      end else begin
         // The response is checked before the new request is queued, since a beat
         // accepted at this edge cannot answer a request accepted at the same edge.
         if (rsp_valid && !rsp_stall) compare_grant(rsp_payload);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POOLS_IN_USE: pools_reg    = csr_data[NPOOL_W-1:0];
               CSR_SLABS_POOL0:  slabs_reg[0] = csr_data;
               CSR_SLABS_POOL1:  slabs_reg[1] = csr_data;
               CSR_SLABS_POOL2:  slabs_reg[2] = csr_data;
               CSR_SLABS_POOL3:  slabs_reg[3] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_grants.insert(expected_grants.size(), apply_request(req_payload));
         end
      end
      grants_pending = expected_grants.size();
   end

endmodule

// ----- verif/multi_pool_slab_allocator_unit_tb.sv -----
// Testbench top for the multi-pool slab allocator: clock, reset, request and register
// stimulus with random gaps and stalls, a watchdog and the verdict.
// Depends on mpsa_pkg, the allocator RTL and slab_grant_checker.
`timescale 1ns / 1ps

module multi_pool_slab_allocator_unit_tb;
   import mpsa_pkg::*;

   localparam int WATCHDOG_LIMIT = 500;
   localparam int SETTLE_CYCLES  = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam logic [CSR_IDX_W-1:0] SLAB_CSR [4] =
      '{CSR_SLABS_POOL0, CSR_SLABS_POOL1, CSR_SLABS_POOL2, CSR_SLABS_POOL3};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CNT_W-1:0]     csr_data;

   int mismatches;
   int outstanding;
   int quiet_cycles;
   int stall_left;
   bit req_gaps_on;
   bit rsp_stalls_on;
   int alloc_sent;
   int free_sent;
   int settings_run;
   int writes_done;

   // Shadow of the register values, used only to aim free beats at live slabs.
   logic [NPOOL_W-1:0] shadow_pools;
   logic [CNT_W-1:0]   shadow_slabs [4];

   multi_pool_slab_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   slab_grant_checker u_grant_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatches),
      .grants_pending (outstanding)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // The receiver draws a fresh stall length after every response beat it takes.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) stall_left = rsp_stalls_on ? $urandom_range(0, 12) : 0;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired after %0d idle cycles", $time, WATCHDOG_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic issue(logic cmd, logic [POOL_W-1:0] pool, logic [SLAB_W-1:0] slab);
      req_type beat;
      int      gap;
      beat.command     = cmd;
      beat.pool_number = pool;
      beat.slab_number = slab;
      gap = req_gaps_on ? $urandom_range(0, 12) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd == CMD_ALLOC) alloc_sent++;
      else free_sent++;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_POOLS_IN_USE: shadow_pools    = value[NPOOL_W-1:0];
         CSR_SLABS_POOL0:  shadow_slabs[0] = value;
         CSR_SLABS_POOL1:  shadow_slabs[1] = value;
         CSR_SLABS_POOL2:  shadow_slabs[2] = value;
         CSR_SLABS_POOL3:  shadow_slabs[3] = value;
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drops the request valid, waits for every response and lets the block settle.
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_item(int alloc_pct);
      int unsigned pools;
      int unsigned pool;
      int unsigned cap;
      pools = (shadow_pools > 4) ? 4 : shadow_pools;
      if ($urandom_range(99) < alloc_pct) begin
         // Pool and slab fields are don't-care on allocate, so they carry noise.
         issue(CMD_ALLOC, POOL_W'($urandom), SLAB_W'($urandom));
      end else if ($urandom_range(99) < 85 && pools > 0) begin
         pool = $urandom_range(pools - 1);
         cap  = (shadow_slabs[pool] > 64) ? 64 : shadow_slabs[pool];
         issue(CMD_FREE, POOL_W'(pool),
               (cap > 0) ? SLAB_W'($urandom_range(cap - 1)) : SLAB_W'($urandom));
      end else begin
         issue(CMD_FREE, POOL_W'($urandom), SLAB_W'($urandom));
      end
   endtask

   function automatic logic [CNT_W-1:0] random_slab_count();
      case ($urandom_range(9))
         0:       return CNT_W'(0);
         1:       return CNT_W'(64);
         2:       return CNT_W'($urandom_range(65, 127));
         3:       return CNT_W'($urandom_range(9, 63));
         default: return CNT_W'($urandom_range(1, 8));
      endcase
   endfunction

   initial begin
      int items;
      int alloc_pct;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      quiet_cycles = 0;
      stall_left   = 0;
      shadow_pools = RST_POOLS_IN_USE;
      foreach (shadow_slabs[p]) shadow_slabs[p] = RST_SLAB_COUNT;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset setting: the start pool rotates, then frees hit a live slab, the same slab
      // again and a slab that was never taken.
      issue(CMD_ALLOC, 2'd3, 6'd63);
      repeat (4) issue(CMD_ALLOC, 2'd0, 6'd0);
      issue(CMD_FREE, 2'd0, 6'd0);
      issue(CMD_FREE, 2'd0, 6'd0);
      issue(CMD_FREE, 2'd3, 6'd63);
      issue(CMD_ALLOC, 2'd0, 6'd0);
      settings_run++;

      // No pool in use: allocation runs dry and every free lands outside.
      quiesce();
      write_register(CSR_POOLS_IN_USE, 7'd0);
      issue(CMD_ALLOC, 2'd0, 6'd0);
      issue(CMD_FREE, 2'd1, 6'd0);
      settings_run++;

      // Oversized registers are clamped, and pool 0 shrinks below a slab it still holds.
      quiesce();
      write_register(CSR_POOLS_IN_USE, 7'd7);
      write_register(CSR_SLABS_POOL0, 7'd0);
      write_register(CSR_SLABS_POOL1, 7'd127);
      write_register(CSR_SLABS_POOL2, 7'd1);
      write_register(CSR_SLABS_POOL3, 7'd2);
      issue(CMD_FREE, 2'd0, 6'd1);
      repeat (3) issue(CMD_ALLOC, 2'd0, 6'd0);
      issue(CMD_FREE, 2'd2, 6'd1);
      settings_run++;

      // One pool left while the start pool points past it; the kept slab comes back.
      quiesce();
      write_register(CSR_POOLS_IN_USE, 7'd1);
      write_register(CSR_SLABS_POOL0, 7'd2);
      write_register(CSR_UNMAPPED, 7'd127);
      issue(CMD_ALLOC, 2'd0, 6'd0);
      issue(CMD_ALLOC, 2'd0, 6'd0);
      issue(CMD_FREE, 2'd0, 6'd1);
      issue(CMD_ALLOC, 2'd0, 6'd0);
      issue(CMD_FREE, 2'd1, 6'd0);
      issue(CMD_FREE, 2'd0, 6'd63);
      settings_run++;

      for (int phase = 0; phase < 12; phase++) begin
         quiesce();
         req_gaps_on   = ($urandom_range(3) != 0);
         rsp_stalls_on = ($urandom_range(3) != 0);
         items         = 50;
         alloc_pct     = $urandom_range(30, 80);
         if (phase == 0) begin
            write_register(CSR_POOLS_IN_USE, 7'd4);
            foreach (SLAB_CSR[p]) write_register(SLAB_CSR[p], 7'd64);
            alloc_pct = 85;
         end else if (phase == 1) begin
            // A single full-size pool is filled until allocation fails.
            write_register(CSR_POOLS_IN_USE, 7'd1);
            write_register(CSR_SLABS_POOL0, 7'd64);
            alloc_pct = 95;
            items     = 80;
         end else begin
            if ($urandom_range(9) < 7) begin
               case ($urandom_range(9))
                  0:       write_register(CSR_POOLS_IN_USE, 7'd0);
                  1:       write_register(CSR_POOLS_IN_USE, CNT_W'($urandom_range(5, 7)));
                  default: write_register(CSR_POOLS_IN_USE, CNT_W'($urandom_range(1, 4)));
               endcase
            end
            foreach (SLAB_CSR[p]) begin
               if ($urandom_range(9) < 7) write_register(SLAB_CSR[p], random_slab_count());
            end
         end
         settings_run++;
         repeat (items) random_item(alloc_pct);
      end

      quiesce();
      $display("Run covered %0d allocate and %0d free beats under %0d register settings",
               alloc_sent, free_sent, settings_run);
      $display("(%0d register writes), with %0d mismatches.", writes_done, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
